### sv/dbag_pkg.sv
// ---------------------------------------------------------------------------
// dbag_pkg: shared types and constants of the disparity tile averager
// Widths, register defaults, configuration indexes and the control/status
// bundles that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package dbag_pkg;

  // geometry limits
  localparam int unsigned MAX_WIDTH        = 1024;
  localparam int unsigned MAX_HEIGHT       = 1024;
  localparam int unsigned MAX_TILE_COLUMNS = 128;
  localparam int unsigned BOX_MIN          = 8;
  localparam int unsigned BOX_MAX          = 16;

  // field widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned INTILE_W  = 4;
  localparam int unsigned TILE_W    = 7;
  localparam int unsigned TIDX_W    = $clog2(MAX_TILE_COLUMNS);
  localparam int unsigned SUM_W     = 24;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned ACC_W     = SUM_W + CNT_W;
  localparam int unsigned DISP_W    = 8;
  localparam int unsigned STEP_W    = $clog2(SUM_W);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned BOX_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE     = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd384;
  localparam logic [BOX_W-1:0] BOX_RESET    = 5'd11;

  // display scaling
  localparam int unsigned CLIP_W       = 12;
  localparam int unsigned PROD_W       = 20;
  localparam logic [CLIP_W-1:0] DISPLAY_MAX = 12'd2048;
  localparam logic [PROD_W-1:0] DISP_ROUND  = 20'd1024;
  localparam int unsigned DISP_SHIFT   = 11;

  // output stream packing
  localparam int unsigned OUT_DATA_W = 40;

  // controller to datapath
  typedef struct packed {
    logic accept;    // latch pixel, read tile entry, advance counters
    logic update;    // accumulate and write tile entry back
    logic div_step;  // one quotient bit
    logic out_load;  // move finished result to output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tile_end;  // latched pixel closes a tile
    logic cnt_zero;  // tile holds no samples
    logic div_done;  // last quotient bit this cycle
    logic out_free;  // output register can take a result
  } ctrl_sts_t;

endpackage

### sv/disparity_block_average_grid.sv
// ---------------------------------------------------------------------------
// disparity_block_average_grid: masked tile averager for a disparity stream
// An item that closes no tile passes through accept and accumulate; one
// that closes a tile goes on through accumulate, a bit-serial divide and
// output load, and skips the divide when the tile is empty. The single
// divider is shared, so a new item is taken only once the last is through;
// output load waits while the output register holds an untaken result.
// Reset clears counters, configuration to defaults and the output valid flag;
// the tile RAM is not cleared (each tile's first pixel overwrites its entry).
// ---------------------------------------------------------------------------
module disparity_block_average_grid
  import dbag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [15:0] disparity
  // tile result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] tile_column, [13:7] tile_row,
                                                // [29:14] average, [37:30] display_value
  output logic                  m_axis_tuser,   // [0] has_samples
  output logic                  m_axis_tlast    // frame_end
);

  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;
  logic [TILE_W-1:0] tile_column, tile_row;
  logic [PIX_W-1:0]  average;
  logic [DISP_W-1:0] display_value;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  dbag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbag_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pix_i           (s_axis_tdata),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .tile_column_o   (tile_column),
    .tile_row_o      (tile_row),
    .average_o       (average),
    .has_samples_o   (m_axis_tuser),
    .display_value_o (display_value),
    .frame_end_o     (m_axis_tlast)
  );

  // result packing, padded to whole bytes
  assign m_axis_tdata = {2'b00, display_value, average, tile_row, tile_column};

endmodule

### sv/dbag_ram.sv
// ---------------------------------------------------------------------------
// dbag_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module dbag_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/dbag_ctrl.sv
// ---------------------------------------------------------------------------
// dbag_ctrl: sequencer of the disparity tile averager
// Accept, accumulate; tile close adds divide (if not empty) and output load.
// ---------------------------------------------------------------------------
module dbag_ctrl
  import dbag_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_OUTPUT
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (!sts_i.tile_end) state_q <= ST_IDLE;
          else if (sts_i.cnt_zero) state_q <= ST_OUTPUT;
          else state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (sts_i.div_done) state_q <= ST_OUTPUT;
        end
        ST_OUTPUT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // commands decoded from state, input valid and output space
  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.update   = (state_q == ST_UPDATE);
  assign cmd_o.div_step = (state_q == ST_DIVIDE);
  assign cmd_o.out_load = (state_q == ST_OUTPUT) && sts_i.out_free;

endmodule

### sv/dbag_datapath.sv
// ---------------------------------------------------------------------------
// dbag_datapath: counters, tile accumulators, divider and output register
// Holds the configuration, the raster position, the per-column tile RAM,
// a bit-serial restoring divider and the result register.
// ---------------------------------------------------------------------------
module dbag_datapath
  import dbag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel
  input  logic [PIX_W-1:0]      pix_i,
  // control
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o,
  // result
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [TILE_W-1:0]     tile_column_o,
  output logic [TILE_W-1:0]     tile_row_o,
  output logic [PIX_W-1:0]      average_o,
  output logic                  has_samples_o,
  output logic [DISP_W-1:0]     display_value_o,
  output logic                  frame_end_o
);

  // ---- configuration registers ----
  logic [DIM_W-1:0] width_q, height_q;
  logic [BOX_W-1:0] box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      box_q    <= BOX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_BOX_SIZE:     box_q    <= cfg_data_i[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated limits, as last index values
  logic [POS_W-1:0]    w_last, h_last;
  logic [INTILE_W-1:0] b_last;

  always_comb begin
    if (width_q == '0) w_last = '0;
    else if (width_q > DIM_W'(MAX_WIDTH)) w_last = POS_W'(MAX_WIDTH - 1);
    else w_last = POS_W'(width_q - DIM_W'(1));

    if (height_q == '0) h_last = '0;
    else if (height_q > DIM_W'(MAX_HEIGHT)) h_last = POS_W'(MAX_HEIGHT - 1);
    else h_last = POS_W'(height_q - DIM_W'(1));

    if (box_q < BOX_W'(BOX_MIN)) b_last = INTILE_W'(BOX_MIN - 1);
    else if (box_q > BOX_W'(BOX_MAX)) b_last = INTILE_W'(BOX_MAX - 1);
    else b_last = INTILE_W'(box_q - BOX_W'(1));
  end

  // ---- raster position counters ----
  logic [POS_W-1:0]    col_pos_q, row_pos_q;
  logic [INTILE_W-1:0] col_in_q, row_in_q;
  logic [TILE_W-1:0]   tcol_q, trow_q;

  logic last_col, last_row, col_end, row_end;

  assign last_col = col_pos_q >= w_last;
  assign last_row = row_pos_q >= h_last;
  assign col_end  = last_col || (col_in_q >= b_last);
  assign row_end  = last_row || (row_in_q >= b_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
      col_in_q  <= '0;
      row_in_q  <= '0;
      tcol_q    <= '0;
      trow_q    <= '0;
    end else if (cmd_i.accept) begin
      if (last_col) begin
        col_pos_q <= '0;
        col_in_q  <= '0;
        tcol_q    <= '0;
        if (last_row) begin
          row_pos_q <= '0;
          row_in_q  <= '0;
          trow_q    <= '0;
        end else begin
          row_pos_q <= row_pos_q + POS_W'(1);
          if (row_in_q >= b_last) begin
            row_in_q <= '0;
            trow_q   <= trow_q + TILE_W'(1);
          end else begin
            row_in_q <= row_in_q + INTILE_W'(1);
          end
        end
      end else begin
        col_pos_q <= col_pos_q + POS_W'(1);
        if (col_end) begin
          col_in_q <= '0;
          tcol_q   <= tcol_q + TILE_W'(1);
        end else begin
          col_in_q <= col_in_q + INTILE_W'(1);
        end
      end
    end
  end

  // ---- item latched at accept ----
  logic [PIX_W-1:0]  pix_q;
  logic              first_q, tile_end_q, frame_end_q;
  logic [TILE_W-1:0] item_col_q, item_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_end_q <= 1'b0;
    end else if (cmd_i.accept) begin
      tile_end_q <= col_end && row_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q       <= pix_i;
      first_q     <= (col_in_q == '0) && (row_in_q == '0);
      frame_end_q <= last_col && last_row;
      item_col_q  <= tcol_q;
      item_row_q  <= trow_q;
    end
  end

  // ---- tile accumulator RAM: {count, sum} per tile column ----
  logic [ACC_W-1:0] acc_rdata, acc_wdata;
  logic [SUM_W-1:0] sum_base, sum_new;
  logic [CNT_W-1:0] cnt_base, cnt_new;
  logic             pix_nz;

  dbag_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_TILE_COLUMNS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (item_col_q[TIDX_W-1:0]),
    .wdata_i (acc_wdata),
    .raddr_i (tcol_q[TIDX_W-1:0]),
    .rdata_o (acc_rdata)
  );

  // first pixel of a tile starts from zero
  always_comb begin
    sum_base  = first_q ? '0 : acc_rdata[SUM_W-1:0];
    cnt_base  = first_q ? '0 : acc_rdata[ACC_W-1:SUM_W];
    pix_nz    = (pix_q != '0);
    sum_new   = pix_nz ? sum_base + SUM_W'(pix_q) : sum_base;
    cnt_new   = pix_nz ? cnt_base + CNT_W'(1) : cnt_base;
    acc_wdata = {cnt_new, sum_new};
  end

  // ---- restoring divider, one quotient bit per cycle ----
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W-1:0]  rem_q, div_q;
  logic [STEP_W-1:0] step_q;
  logic              has_q;
  logic [CNT_W:0]    partial, diff;

  assign partial = {rem_q, quo_q[SUM_W-1]};
  assign diff    = partial - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      quo_q  <= sum_new;
      rem_q  <= '0;
      div_q  <= cnt_new;
      step_q <= '0;
      has_q  <= (cnt_new != '0);
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
      if (partial >= {1'b0, div_q}) begin
        rem_q <= diff[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= partial[CNT_W-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // ---- display byte: (min(avg,2048)*255 + 1024) >> 11 ----
  logic [CLIP_W-1:0] clipped;
  logic [PROD_W-1:0] scaled;

  always_comb begin
    clipped = (quo_q > SUM_W'(DISPLAY_MAX)) ? DISPLAY_MAX : quo_q[CLIP_W-1:0];
    scaled  = (PROD_W'(clipped) << 8) - PROD_W'(clipped) + DISP_ROUND;
  end

  // ---- output register ----
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      tile_column_o   <= item_col_q;
      tile_row_o      <= item_row_q;
      average_o       <= has_q ? quo_q[PIX_W-1:0] : '0;
      has_samples_o   <= has_q;
      display_value_o <= has_q ? scaled[DISP_SHIFT +: DISP_W] : '0;
      frame_end_o     <= frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---- status ----
  assign sts_o.tile_end = tile_end_q;
  assign sts_o.cnt_zero = (cnt_new == '0);
  assign sts_o.div_done = (step_q == STEP_W'(SUM_W - 1));
  assign sts_o.out_free = out_free;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the disparity tile averager
// Streams disparity pixels in raster order under several frame geometries,
// predicts every finished tile (mean, sample flag, display byte, frame end)
// with a behavioural copy of the tile grid and compares each result item.
// ---------------------------------------------------------------------------
module tb_top
  import dbag_pkg::*;
();

  localparam int SETTLE_CYCLES = 40;     // covers the divide path
  localparam int DRAIN_LIMIT   = 20000;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 240;
  localparam int PHASE_ITEMS   = 30;

  // no register lives at this index; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    bit [TILE_W-1:0] tcol;
    bit [TILE_W-1:0] trow;
    bit [PIX_W-1:0]  avg;
    bit              has;
    bit [DISP_W-1:0] disp;
    bit              last;
  } tile_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;
  typedef enum int {FILL_ZERO, FILL_FULL, FILL_SPARSE, FILL_MIXED} frame_fill_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [PIX_W-1:0]     value;
    bit                   typed;
    tile_result_t         res;
  } step_row_t;

  // directed walk: reset defaults, a mid-frame shrink, 1x1 frames hitting the
  // clamps and the display rounding, a spare index, then a small partial tile
  localparam int N_DIRECTED = 24;
  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_PIX, CFG_SPARE,        16'h0010, 1'b0, '0},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  16'd1,    1'b0, '0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd1,    1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'hFFFF, 1'b1, '{7'd0, 7'd0, 16'd32775, 1'b1, 8'd255, 1'b1}},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  16'd0,    1'b0, '0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd0,    1'b0, '0},
    '{ROW_CFG, CFG_BOX_SIZE,     16'd0,    1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h0000, 1'b1, '{7'd0, 7'd0, 16'd0,     1'b0, 8'd0,   1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'hFFFF, 1'b1, '{7'd0, 7'd0, 16'd65535, 1'b1, 8'd255, 1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'd1,    1'b1, '{7'd0, 7'd0, 16'd1,     1'b1, 8'd0,   1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'd4,    1'b1, '{7'd0, 7'd0, 16'd4,     1'b1, 8'd0,   1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'd5,    1'b1, '{7'd0, 7'd0, 16'd5,     1'b1, 8'd1,   1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'd2048, 1'b1, '{7'd0, 7'd0, 16'd2048,  1'b1, 8'd255, 1'b1}},
    '{ROW_PIX, CFG_SPARE,        16'd2049, 1'b1, '{7'd0, 7'd0, 16'd2049,  1'b1, 8'd255, 1'b1}},
    '{ROW_CFG, CFG_SPARE,        16'h07FF, 1'b0, '0},
    '{ROW_CFG, CFG_IMAGE_WIDTH,  16'd3,    1'b0, '0},
    '{ROW_CFG, CFG_IMAGE_HEIGHT, 16'd2,    1'b0, '0},
    '{ROW_CFG, CFG_BOX_SIZE,     16'd31,   1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h0000, 1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h1234, 1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h0000, 1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h0800, 1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h0000, 1'b0, '0},
    '{ROW_PIX, CFG_SPARE,        16'h00FF, 1'b0, '0}
  };

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [PIX_W-1:0]      s_axis_tdata;   // [15:0] disparity
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [6:0] tile_column, [13:7] tile_row,
                                         // [29:14] average, [37:30] display_value
  logic                  m_axis_tuser;   // [0] has_samples
  logic                  m_axis_tlast;   // frame_end

  // bench control
  tile_result_t tiles_due [$];
  reg_write_t   cfg_queue [$];
  int           errors         = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_request   = 0;

  // predictor copy of the registers and the tile grid
  bit [DIM_W-1:0]    geo_width  = WIDTH_RESET;
  bit [DIM_W-1:0]    geo_height = HEIGHT_RESET;
  bit [BOX_W-1:0]    geo_box    = BOX_RESET;
  bit [SUM_W-1:0]    acc_sum [MAX_TILE_COLUMNS];
  bit [CNT_W-1:0]    acc_cnt [MAX_TILE_COLUMNS];
  bit [POS_W-1:0]    pos_x = '0;
  bit [POS_W-1:0]    pos_y = '0;
  bit [INTILE_W-1:0] sub_x = '0;
  bit [INTILE_W-1:0] sub_y = '0;
  bit [TILE_W-1:0]   grid_x = '0;
  bit [TILE_W-1:0]   grid_y = '0;

  disparity_block_average_grid DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic note_error(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // frame dimension as the block sees it after saturation
  function automatic int unsigned eff_dim(input bit [DIM_W-1:0] raw, input int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // advance the tile grid by one pixel; returns 1 when a tile closes
  function automatic bit grid_step(input bit [PIX_W-1:0] px, output tile_result_t res);
    int unsigned w, h, b, idx, quot, clipped;
    bit last_col, last_row, col_end, row_end;
    w = eff_dim(geo_width, MAX_WIDTH);
    h = eff_dim(geo_height, MAX_HEIGHT);
    b = (geo_box < BOX_MIN) ? BOX_MIN : ((geo_box > BOX_MAX) ? BOX_MAX : geo_box);
    idx = grid_x % MAX_TILE_COLUMNS;
    last_col = pos_x >= w - 1;
    last_row = pos_y >= h - 1;
    col_end  = last_col || (sub_x >= b - 1);
    row_end  = last_row || (sub_y >= b - 1);
    res = '0;

    // first pixel of a tile starts a fresh accumulator
    if (sub_x == 0 && sub_y == 0) begin
      acc_sum[idx] = '0;
      acc_cnt[idx] = '0;
    end
    if (px != 0) begin
      acc_sum[idx] = acc_sum[idx] + px;
      acc_cnt[idx] = acc_cnt[idx] + 1'b1;
    end

    if (col_end && row_end) begin
      res.tcol = grid_x;
      res.trow = grid_y;
      res.last = last_col && last_row;
      if (acc_cnt[idx] != 0) begin
        quot     = acc_sum[idx] / acc_cnt[idx];
        clipped  = (quot < DISPLAY_MAX) ? quot : DISPLAY_MAX;
        res.avg  = quot[PIX_W-1:0];
        res.has  = 1'b1;
        res.disp = DISP_W'((clipped * 255 + DISP_ROUND) >> DISP_SHIFT);
      end
    end

    // raster counters
    if (last_col) begin
      pos_x  = '0;
      sub_x  = '0;
      grid_x = '0;
      if (last_row) begin
        pos_y  = '0;
        sub_y  = '0;
        grid_y = '0;
      end else begin
        pos_y = pos_y + 1'b1;
        if (sub_y >= b - 1) begin
          sub_y  = '0;
          grid_y = grid_y + 1'b1;
        end else begin
          sub_y = sub_y + 1'b1;
        end
      end
    end else begin
      pos_x = pos_x + 1'b1;
      if (col_end) begin
        sub_x  = '0;
        grid_x = grid_x + 1'b1;
      end else begin
        sub_x = sub_x + 1'b1;
      end
    end
    return col_end && row_end;
  endfunction

  // offer one pixel item; valid stays high after acceptance
  task automatic push_pixel(input bit [PIX_W-1:0] px, input bit typed,
                            input tile_result_t typed_res);
    tile_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    if (grid_step(px, res)) tiles_due.push_back(typed ? typed_res : res);
  endtask

  // wait for the block to go quiet, then write every queued register
  task automatic flush_config();
    reg_write_t wr;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tiles_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (cfg_queue.size() != 0) begin
      wr = cfg_queue.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr.idx;
      cfg_data_i  <= wr.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      case (wr.idx)
        CFG_IMAGE_WIDTH:  geo_width  = wr.data;
        CFG_IMAGE_HEIGHT: geo_height = wr.data;
        CFG_BOX_SIZE:     geo_box    = wr.data[BOX_W-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // one whole frame at the current geometry
  task automatic stream_frame(input frame_fill_e fill, input bit drain_midway);
    int unsigned n_pix;
    bit [PIX_W-1:0] px;
    n_pix = eff_dim(geo_width, MAX_WIDTH) * eff_dim(geo_height, MAX_HEIGHT);
    for (int unsigned i = 0; i < n_pix; i++) begin
      // sender holds back until every pending tile has come out
      if (drain_midway && i == n_pix / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (tiles_due.size() != 0);
      end
      case (fill)
        FILL_ZERO:   px = '0;
        FILL_FULL:   px = '1;
        FILL_SPARSE: px = ($urandom_range(0, 4) == 0) ? PIX_W'($urandom) : '0;
        default: begin
          if ($urandom_range(0, 3) == 0) px = '0;
          else begin
            case ($urandom_range(0, 2))
              0:       px = PIX_W'($urandom);
              1:       px = PIX_W'($urandom_range(1, 4095));
              default: px = PIX_W'($urandom_range(2040, 2056));
            endcase
          end
        end
      endcase
      push_pixel(px, 1'b0, '0);
    end
  endtask

  // result side: check each accepted item, then decide the next ready
  initial begin : result_sink
    tile_result_t want;
    tile_result_t got;
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.tcol = m_axis_tdata[6:0];
        got.trow = m_axis_tdata[13:7];
        got.avg  = m_axis_tdata[29:14];
        got.disp = m_axis_tdata[37:30];
        got.has  = m_axis_tuser;
        got.last = m_axis_tlast;
        if (tiles_due.size() == 0) begin
          note_error($sformatf("unexpected tile result col %0d row %0d", got.tcol, got.trow));
        end else begin
          want = tiles_due.pop_front();
          if (got.tcol !== want.tcol)
            note_error($sformatf("tile_column got %0d want %0d", got.tcol, want.tcol));
          if (got.trow !== want.trow)
            note_error($sformatf("tile_row got %0d want %0d", got.trow, want.trow));
          if (got.avg !== want.avg)
            note_error($sformatf("average got %0d want %0d (tile %0d,%0d)",
                                 got.avg, want.avg, want.tcol, want.trow));
          if (got.has !== want.has)
            note_error($sformatf("has_samples got %0b want %0b", got.has, want.has));
          if (got.disp !== want.disp)
            note_error($sformatf("display_value got %0d want %0d", got.disp, want.disp));
          if (got.last !== want.last)
            note_error($sformatf("frame_end got %0b want %0b", got.last, want.last));
        end
      end
      // a long hold lets the block fill up and push back on its input
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // stimulus
  initial begin : pixel_source
    int random_items;
    int phase_items;
    int phase;
    int r;
    bit [DIM_W-1:0] w_raw;
    bit [DIM_W-1:0] h_raw;
    bit [CFG_DATA_W-1:0] b_raw;
    frame_fill_e fill;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_IMAGE_WIDTH;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        cfg_queue.push_back('{DIRECTED[i].idx, DIRECTED[i].value[CFG_DATA_W-1:0]});
      end else begin
        if (cfg_queue.size() != 0) flush_config();
        push_pixel(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    // a long single row and a tall single column; box written with high bits set
    cfg_queue.push_back('{CFG_IMAGE_WIDTH,  11'd96});
    cfg_queue.push_back('{CFG_IMAGE_HEIGHT, 11'd1});
    cfg_queue.push_back('{CFG_BOX_SIZE,     11'd8});
    flush_config();
    stream_frame(FILL_MIXED, 1'b0);
    cfg_queue.push_back('{CFG_IMAGE_WIDTH,  11'd1});
    cfg_queue.push_back('{CFG_IMAGE_HEIGHT, 11'd96});
    cfg_queue.push_back('{CFG_BOX_SIZE,     11'h7E8});
    flush_config();
    stream_frame(FILL_MIXED, 1'b0);

    // random geometries, cycling through the idling patterns
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      w_raw = DIM_W'($urandom_range(1, 24));
      h_raw = DIM_W'($urandom_range(1, 12));
      if ($urandom_range(0, 19) == 0) w_raw = '0;
      if ($urandom_range(0, 19) == 0) h_raw = '0;
      if ($urandom_range(0, 6) == 0) b_raw = CFG_DATA_W'($urandom_range(0, 2047));
      else b_raw = CFG_DATA_W'($urandom_range(BOX_MIN, BOX_MAX));
      cfg_queue.push_back('{CFG_IMAGE_WIDTH,  w_raw});
      cfg_queue.push_back('{CFG_IMAGE_HEIGHT, h_raw});
      cfg_queue.push_back('{CFG_BOX_SIZE,     b_raw});
      flush_config();

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      if (phase == 0) hold_request = LONG_HOLD;

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 5);
        fill = (r >= 3) ? FILL_MIXED : frame_fill_e'(r);
        stream_frame(fill, phase == 1 && phase_items == 0);
        phase_items += eff_dim(geo_width, MAX_WIDTH) * eff_dim(geo_height, MAX_HEIGHT);
      end
      random_items += phase_items;
      phase++;
    end

    // drain with the result side always ready
    s_axis_tvalid  <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int c = 0; c < DRAIN_LIMIT && tiles_due.size() != 0; c++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tiles_due.size() != 0)
      note_error($sformatf("%0d tile results never arrived", tiles_due.size()));

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
sv/dbag_pkg.sv
sv/dbag_ram.sv
sv/dbag_ctrl.sv
sv/dbag_datapath.sv
sv/disparity_block_average_grid.sv
verif/tb_top.sv
